// ===== rtl/cmm_pkg.sv =====
// Shared types and constants of the complex matrix multiplier.
package cmm_pkg;

    localparam int IDX_W      = 3;   // row/column index width on the ports
    localparam int CFG_W      = 4;   // dimension register width
    localparam int FIELD_W    = 16;  // width of a part field on the input port
    localparam int MAX_PART_W = 24;  // widest part the stores may hold
    localparam int SUM_W      = 40;  // width of a product sum
    localparam int IN_DATA_W  = 40;  // row, col, real, imag, padded to bytes
    localparam int OUT_DATA_W = 88;  // row, col, sum real, sum imag, padded

    typedef logic [1:0] cmd_t;
    localparam cmd_t CMD_LOAD_A = 2'd0;
    localparam cmd_t CMD_LOAD_B = 2'd1;
    localparam cmd_t CMD_START  = 2'd2;

    typedef logic [1:0] cfg_idx_t;
    localparam cfg_idx_t CFG_ROWS_A    = 2'd0;
    localparam cfg_idx_t CFG_INNER_DIM = 2'd1;
    localparam cfg_idx_t CFG_COLS_B    = 2'd2;

    localparam logic [CFG_W-1:0] DIM_RESET = 4'd8;

    typedef struct packed {
        logic [CFG_W-1:0] rows_a;
        logic [CFG_W-1:0] inner_dim;
        logic [CFG_W-1:0] cols_b;
    } cmm_dims_t;

    // Travels with each memory read down the MAC pipeline.
    typedef struct packed {
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
        logic             first;    // first term of a dot product
        logic             last_k;   // last term of a dot product
        logic             last_el;  // last product element of the run
    } cmm_tag_t;

endpackage

// ===== rtl/complex_matrix_multiply.sv =====
// Complex matrix multiplier top level: stores for A and B, sequencer, MAC.
//
//  channel  | beat moves                      | handshake
//  ---------+---------------------------------+------------------------------
//  s_axis   | load A/B element or start       | s_axis_tvalid / s_axis_tready
//  m_axis   | one product element, tlast end | m_axis_tvalid / m_axis_tready
//  cfg      | dimension register write        | cfg_write, no wait
//
//  Load beats are taken one per cycle while no run is busy; each in-range load
//  writes one store entry. A start keeps s_axis_tready low for its
//  rows_a*cols_b*inner_dim MAC steps (effective dimensions): one complex MAC
//  step per cycle while m_axis does not stall, set by the single read port of each store, then two pipeline stages.
//  s_axis_tready is low from a start until its last element reaches the
//  output register; m_axis back-pressure freezes the whole MAC pipeline.
//  Reset clears control only; store contents are undefined until loaded.
module complex_matrix_multiply #(
    parameter int MAX_DIM    = 8,
    parameter int PART_WIDTH = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // row_index[2:0], col_index[5:3], real_part[21:6], imag_part[37:22]
    input  logic [cmm_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    // cmd[1:0]
    input  logic [1:0]                         s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // out_row[2:0], out_col[5:3], sum_real[45:6], sum_imag[85:46]
    output logic [cmm_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    output logic                               m_axis_tlast,
    input  logic                               cfg_write,
    input  logic [1:0]                         cfg_index,
    input  logic [cmm_pkg::CFG_W-1:0]          cfg_data
);

    localparam int DEPTH  = MAX_DIM * MAX_DIM;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int DATA_W = 2 * PART_WIDTH;

    cmm_pkg::cmm_dims_t dims_reg, dims_next;
    logic               busy_reg, busy_next;

    logic                       in_accept;
    cmm_pkg::cmd_t              cmd;
    logic [cmm_pkg::IDX_W-1:0]  row_index, col_index;
    logic [cmm_pkg::FIELD_W-1:0] real_field, imag_field;
    logic [cmm_pkg::MAX_PART_W-1:0] real_ext, imag_ext;
    logic [DATA_W-1:0]          load_data;
    logic [ADDR_W-1:0]          load_addr;
    logic                       load_ok, we_a, we_b, start;

    logic                       issue, adv, done;
    logic [ADDR_W-1:0]          addr_a, addr_b;
    cmm_pkg::cmm_tag_t          tag;
    logic [DATA_W-1:0]          rd_a, rd_b;

    logic [cmm_pkg::IDX_W-1:0]  out_row, out_col;
    logic signed [cmm_pkg::SUM_W-1:0] out_re, out_im;
    logic                       out_last;

    assign cmd        = s_axis_tuser;
    assign row_index  = s_axis_tdata[2:0];
    assign col_index  = s_axis_tdata[5:3];
    assign real_field = s_axis_tdata[21:6];
    assign imag_field = s_axis_tdata[37:22];

    assign in_accept = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = !busy_reg;

    // Parts are the low PART_WIDTH bits of the field, zero-filled above it.
    assign real_ext  = cmm_pkg::MAX_PART_W'(real_field);
    assign imag_ext  = cmm_pkg::MAX_PART_W'(imag_field);
    assign load_data = {imag_ext[PART_WIDTH-1:0], real_ext[PART_WIDTH-1:0]};
    assign load_addr = ADDR_W'(int'(row_index) * MAX_DIM + int'(col_index));
    assign load_ok   = (int'(row_index) < MAX_DIM) && (int'(col_index) < MAX_DIM);

    assign we_a  = in_accept && (cmd == cmm_pkg::CMD_LOAD_A) && load_ok;
    assign we_b  = in_accept && (cmd == cmm_pkg::CMD_LOAD_B) && load_ok;
    assign start = in_accept && (cmd == cmm_pkg::CMD_START);

    always_comb
    begin
        dims_next = dims_reg;
        if (cfg_write)
        begin
            unique case (cfg_index)
                cmm_pkg::CFG_ROWS_A:    dims_next.rows_a    = cfg_data;
                cmm_pkg::CFG_INNER_DIM: dims_next.inner_dim = cfg_data;
                cmm_pkg::CFG_COLS_B:    dims_next.cols_b    = cfg_data;
                default:                dims_next           = dims_reg;
            endcase
        end
    end

    always_comb
    begin
        busy_next = busy_reg;
        if (start)
        begin
            busy_next = 1'b1;
        end
        else if (done)
        begin
            busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dims_reg.rows_a    <= cmm_pkg::DIM_RESET;
            dims_reg.inner_dim <= cmm_pkg::DIM_RESET;
            dims_reg.cols_b    <= cmm_pkg::DIM_RESET;
            busy_reg           <= 1'b0;
        end
        else
        begin
            dims_reg <= dims_next;
            busy_reg <= busy_next;
        end
    end

    cmm_mem #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W),
        .DATA_W (DATA_W)
    ) u_store_a (
        .clk   (clk),
        .we    (we_a),
        .waddr (load_addr),
        .wdata (load_data),
        .re    (issue && adv),
        .raddr (addr_a),
        .rdata (rd_a)
    );

    cmm_mem #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W),
        .DATA_W (DATA_W)
    ) u_store_b (
        .clk   (clk),
        .we    (we_b),
        .waddr (load_addr),
        .wdata (load_data),
        .re    (issue && adv),
        .raddr (addr_b),
        .rdata (rd_b)
    );

    cmm_seq #(
        .MAX_DIM (MAX_DIM),
        .ADDR_W  (ADDR_W)
    ) u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .dims   (dims_reg),
        .adv    (adv),
        .issue  (issue),
        .addr_a (addr_a),
        .addr_b (addr_b),
        .tag    (tag)
    );

    cmm_mac #(
        .PART_WIDTH (PART_WIDTH)
    ) u_mac (
        .clk       (clk),
        .rst_n     (rst_n),
        .issue     (issue),
        .tag       (tag),
        .rd_a      (rd_a),
        .rd_b      (rd_b),
        .out_ready (m_axis_tready),
        .adv       (adv),
        .done      (done),
        .out_valid (m_axis_tvalid),
        .out_row   (out_row),
        .out_col   (out_col),
        .out_re    (out_re),
        .out_im    (out_im),
        .out_last  (out_last)
    );

    assign m_axis_tdata = {2'b00, out_im, out_re, out_col, out_row};
    assign m_axis_tlast = out_last;

endmodule

// ===== rtl/cmm_mem.sv =====
// Simple dual-port store: one write port, one registered read port.
module cmm_mem #(
    parameter int DEPTH  = 64,
    parameter int ADDR_W = 6,
    parameter int DATA_W = 32
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/cmm_seq.sv =====
// Read sequencer: walks i, j, k over the product and addresses both stores.
module cmm_seq #(
    parameter int MAX_DIM = 8,
    parameter int ADDR_W  = 6
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  cmm_pkg::cmm_dims_t  dims,
    input  logic                adv,
    output logic                issue,
    output logic [ADDR_W-1:0]   addr_a,
    output logic [ADDR_W-1:0]   addr_b,
    output cmm_pkg::cmm_tag_t   tag
);

    // Effective dimension minus one: zero acts as one, oversize as MAX_DIM.
    function automatic logic [cmm_pkg::IDX_W-1:0] last_idx(
        input logic [cmm_pkg::CFG_W-1:0] d
    );
        logic [cmm_pkg::IDX_W-1:0] r;
        if (d == '0)
        begin
            r = '0;
        end
        else if (int'(d) > MAX_DIM)
        begin
            r = cmm_pkg::IDX_W'(MAX_DIM - 1);
        end
        else
        begin
            r = cmm_pkg::IDX_W'(d - 1'b1);
        end
        return r;
    endfunction

    logic                       active_reg, active_next;
    logic [cmm_pkg::IDX_W-1:0]  i_reg, i_next;
    logic [cmm_pkg::IDX_W-1:0]  j_reg, j_next;
    logic [cmm_pkg::IDX_W-1:0]  k_reg, k_next;
    logic [cmm_pkg::IDX_W-1:0]  last_i_reg, last_i_next;
    logic [cmm_pkg::IDX_W-1:0]  last_j_reg, last_j_next;
    logic [cmm_pkg::IDX_W-1:0]  last_k_reg, last_k_next;

    always_comb
    begin
        active_next = active_reg;
        i_next      = i_reg;
        j_next      = j_reg;
        k_next      = k_reg;
        last_i_next = last_i_reg;
        last_j_next = last_j_reg;
        last_k_next = last_k_reg;
        if (start)
        begin
            active_next = 1'b1;
            i_next      = '0;
            j_next      = '0;
            k_next      = '0;
            last_i_next = last_idx(dims.rows_a);
            last_j_next = last_idx(dims.cols_b);
            last_k_next = last_idx(dims.inner_dim);
        end
        else if (active_reg && adv)
        begin
            if (k_reg != last_k_reg)
            begin
                k_next = k_reg + 1'b1;
            end
            else
            begin
                k_next = '0;
                if (j_reg != last_j_reg)
                begin
                    j_next = j_reg + 1'b1;
                end
                else
                begin
                    j_next = '0;
                    if (i_reg != last_i_reg)
                    begin
                        i_next = i_reg + 1'b1;
                    end
                    else
                    begin
                        active_next = 1'b0;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
        end
        else
        begin
            active_reg <= active_next;
        end
    end

    always_ff @(posedge clk)
    begin
        i_reg      <= i_next;
        j_reg      <= j_next;
        k_reg      <= k_next;
        last_i_reg <= last_i_next;
        last_j_reg <= last_j_next;
        last_k_reg <= last_k_next;
    end

    assign issue  = active_reg;
    assign addr_a = ADDR_W'(int'(i_reg) * MAX_DIM + int'(k_reg));
    assign addr_b = ADDR_W'(int'(k_reg) * MAX_DIM + int'(j_reg));

    always_comb
    begin
        tag.row     = i_reg;
        tag.col     = j_reg;
        tag.first   = (k_reg == '0);
        tag.last_k  = (k_reg == last_k_reg);
        tag.last_el = (k_reg == last_k_reg) && (j_reg == last_j_reg) &&
                      (i_reg == last_i_reg);
    end

endmodule

// ===== rtl/cmm_mac.sv =====
// Complex multiply-accumulate pipeline with the result output register.
module cmm_mac #(
    parameter int PART_WIDTH = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            issue,
    input  cmm_pkg::cmm_tag_t               tag,
    input  logic [2*PART_WIDTH-1:0]         rd_a,     // {imag, real}
    input  logic [2*PART_WIDTH-1:0]         rd_b,     // {imag, real}
    input  logic                            out_ready,
    output logic                            adv,
    output logic                            done,
    output logic                            out_valid,
    output logic [cmm_pkg::IDX_W-1:0]       out_row,
    output logic [cmm_pkg::IDX_W-1:0]       out_col,
    output logic signed [cmm_pkg::SUM_W-1:0] out_re,
    output logic signed [cmm_pkg::SUM_W-1:0] out_im,
    output logic                            out_last
);

    localparam int PROD_W = 2 * PART_WIDTH;
    localparam int SUM_W  = cmm_pkg::SUM_W;

    logic signed [PART_WIDTH-1:0] a_re, a_im, b_re, b_im;

    logic                v1_reg, v2_reg;
    cmm_pkg::cmm_tag_t   t1_reg, t2_reg;
    logic signed [PROD_W-1:0] p_rr_reg, p_ii_reg, p_ri_reg, p_ir_reg;
    logic signed [SUM_W-1:0]  acc_re_reg, acc_im_reg;
    logic signed [SUM_W-1:0]  base_re, base_im, sum_re, sum_im;

    logic                      out_valid_reg, out_valid_next;
    logic [cmm_pkg::IDX_W-1:0] out_row_reg, out_col_reg;
    logic signed [SUM_W-1:0]   out_re_reg, out_im_reg;
    logic                      out_last_reg;
    logic                      commit;

    assign a_re = $signed(rd_a[PART_WIDTH-1:0]);
    assign a_im = $signed(rd_a[PROD_W-1:PART_WIDTH]);
    assign b_re = $signed(rd_b[PART_WIDTH-1:0]);
    assign b_im = $signed(rd_b[PROD_W-1:PART_WIDTH]);

    // The whole pipeline freezes while a result waits at the output.
    assign adv    = !(out_valid_reg && !out_ready);
    assign commit = adv && v2_reg && t2_reg.last_k;
    assign done   = commit && t2_reg.last_el;

    always_comb
    begin
        base_re = t2_reg.first ? '0 : acc_re_reg;
        base_im = t2_reg.first ? '0 : acc_im_reg;
        sum_re  = base_re + SUM_W'(p_rr_reg) - SUM_W'(p_ii_reg);
        sum_im  = base_im + SUM_W'(p_ri_reg) + SUM_W'(p_ir_reg);
    end

    always_comb
    begin
        out_valid_next = (out_valid_reg && !out_ready) || commit;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (adv)
            begin
                v1_reg <= issue;
                v2_reg <= v1_reg;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            t1_reg   <= tag;
            t2_reg   <= t1_reg;
            p_rr_reg <= PROD_W'(a_re) * PROD_W'(b_re);
            p_ii_reg <= PROD_W'(a_im) * PROD_W'(b_im);
            p_ri_reg <= PROD_W'(a_re) * PROD_W'(b_im);
            p_ir_reg <= PROD_W'(a_im) * PROD_W'(b_re);
            if (v2_reg)
            begin
                acc_re_reg <= sum_re;
                acc_im_reg <= sum_im;
            end
        end
        if (commit)
        begin
            out_row_reg  <= t2_reg.row;
            out_col_reg  <= t2_reg.col;
            out_re_reg   <= sum_re;
            out_im_reg   <= sum_im;
            out_last_reg <= t2_reg.last_el;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_row   = out_row_reg;
    assign out_col   = out_col_reg;
    assign out_re    = out_re_reg;
    assign out_im    = out_im_reg;
    assign out_last  = out_last_reg;

endmodule

// ===== rtl/cmm_checker.sv =====
// Port-level checks for the complex matrix multiplier, bound to the top.
module cmm_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           s_axis_tvalid,
    input logic                           s_axis_tready,
    input logic [1:0]                     s_axis_tuser,
    input logic                           m_axis_tvalid,
    input logic                           m_axis_tready,
    input logic [cmm_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    input logic                           m_axis_tlast
);

    // A start always closes the input; the check covers the state right after the start beat.
    a_start_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready && s_axis_tuser == cmm_pkg::CMD_START)
        |=> !s_axis_tready)
        else $error("input still open after start beat");

    // Loads and unused commands never close the input.
    a_load_keeps_open: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready && s_axis_tuser != cmm_pkg::CMD_START)
        |=> s_axis_tready)
        else $error("input closed after non-start beat");

    // A stalled result holds.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready)
        |=> (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)))
        else $error("output beat changed while stalled");

    // Once the input reopens, the last result of the run has been produced.
    a_reopen_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        ($rose(s_axis_tready) && m_axis_tvalid) |-> m_axis_tlast)
        else $error("input reopened before last element");

endmodule

bind complex_matrix_multiply cmm_checker u_cmm_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);
